// ----- src/deq_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue with search
// no dependencies

package deq_pkg;

  localparam int unsigned OpcodeW   = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CountOutW = 7;

  // input item: opcode in the low bits, value above, padded to whole bytes
  localparam int unsigned STdataW   = 40;
  // result item: entry_count, found, refused, padded to whole bytes
  localparam int unsigned MTdataW   = 16;

  typedef enum logic [OpcodeW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } opcode_e;

endpackage

// ----- src/deq_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies

module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/double_ended_queue_with_search_core.sv -----
`timescale 1ns / 1ps
// double-ended queue of signed 32-bit values in a ring ram, with a membership search
// depends on deq_pkg and deq_ram
//
// push, pop and unused opcodes register their result in the cycle after acceptance.
// search: one ram read per stored entry, stopping at the first match; the result is
//   registered once the last entry read is compared; an empty queue answers like a pop.
// throughput: one item in flight; the ram read port paces the scan at one entry a cycle.
// reset: asynchronous active-low, clears front index, count and the handshake state;
//   the ram holds no reset value and is read only at entries that are in the queue.

module double_ended_queue_with_search_core
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [STdataW-1:0] s_axis_tdata_i,  // [2:0] opcode, [34:3] item_value, [39:35] zero
  // result items
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [MTdataW-1:0] m_axis_tdata_o   // [6:0] entry_count, [7] found, [8] refused,
                                              // [15:9] zero
);

  localparam int unsigned AW = $clog2(DEPTH);      // ring index width
  localparam int unsigned CW = $clog2(DEPTH + 1);  // count width, holds 0..DEPTH

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // ring position front + offset, offset below DEPTH*2 - front, single wrap
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] front,
                                             input logic [CW-1:0] offset);
    logic [CW:0] sum;
    sum = (CW+1)'(front) + (CW+1)'(offset);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // input unpacking
  opcode_e            in_op;
  logic signed [ValueW-1:0] in_val;
  assign in_op  = opcode_e'(s_axis_tdata_i[OpcodeW-1:0]);
  assign in_val = s_axis_tdata_i[OpcodeW +: ValueW];

  // state
  state_e            state_q, state_d;
  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     scan_idx_q, scan_idx_d;   // offset of the entry whose data returns now
  logic signed [ValueW-1:0] key_q, key_d;      // value under search
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     out_count_q, out_count_d;
  logic              out_found_q, out_found_d;
  logic              out_refused_q, out_refused_d;

  // ram port signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic is_full;
  logic is_empty;
  logic scan_hit;
  logic scan_last;
  logic [CW-1:0] scan_next;

  deq_ram #(
    .Width(ValueW),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // the result register frees up either empty or being taken this cycle
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign scan_hit  = (ram_rdata == key_q);
  assign scan_next = CW'(scan_idx_q) + CW'(1);
  assign scan_last = (scan_next == count_q);

  always_comb begin
    state_d       = state_q;
    front_d       = front_q;
    count_d       = count_q;
    scan_idx_d    = scan_idx_q;
    key_d         = key_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_count_d   = out_count_q;
    out_found_d   = out_found_q;
    out_refused_d = out_refused_q;

    ram_we    = 1'b0;
    ram_waddr = ring_pos(front_q, count_q);
    ram_wdata = in_val;
    ram_re    = 1'b0;
    ram_raddr = front_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // default result: count unchanged, no hit, not refused
          out_valid_d   = 1'b1;
          out_found_d   = 1'b0;
          out_refused_d = 1'b0;
          out_count_d   = count_q;
          case (in_op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                out_refused_d = 1'b1;
              end else begin
                front_d     = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
                ram_we      = 1'b1;
                ram_waddr   = front_d;
                count_d     = count_q + CW'(1);
                out_count_d = count_d;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                out_refused_d = 1'b1;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = ring_pos(front_q, count_q);
                count_d     = count_q + CW'(1);
                out_count_d = count_d;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_refused_d = 1'b1;
              end else begin
                front_d     = ring_pos(front_q, CW'(1));
                count_d     = count_q - CW'(1);
                out_count_d = count_d;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_refused_d = 1'b1;
              end else begin
                count_d     = count_q - CW'(1);
                out_count_d = count_d;
              end
            end
            OP_SEARCH: begin
              // empty queue answers at once; otherwise read the front entry
              if (!is_empty) begin
                out_valid_d = 1'b0;
                key_d       = in_val;
                scan_idx_d  = '0;
                ram_re      = 1'b1;
                ram_raddr   = front_q;
                state_d     = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // result register is empty here: it was free when the search was taken
        if (scan_hit || scan_last) begin
          out_valid_d   = 1'b1;
          out_count_d   = count_q;
          out_found_d   = scan_hit;
          out_refused_d = 1'b0;
          state_d       = ST_IDLE;
        end else begin
          scan_idx_d = scan_next[AW-1:0];
          ram_re     = 1'b1;
          ram_raddr  = ring_pos(front_q, scan_next);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    scan_idx_q    <= scan_idx_d;
    key_q         <= key_d;
    out_count_q   <= out_count_d;
    out_found_q   <= out_found_d;
    out_refused_q <= out_refused_d;
  end

  // count masked to the 7-bit field
  logic [31:0] out_count_ext;
  assign out_count_ext = 32'(out_count_q);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_refused_q, out_found_q, out_count_ext[CountOutW-1:0]};

endmodule

// ----- verif/tb_double_ended_queue_with_search_core.sv -----
`timescale 1ns / 1ps
// self-checking testbench for double_ended_queue_with_search_core: tracks the deque contents
// item by item and checks every result; depends on deq_pkg and the core it drives

module tb_double_ended_queue_with_search_core
  import deq_pkg::*;
();

  localparam int unsigned Depth     = 64;
  localparam int unsigned PhaseLen  = 95;     // random items per phase
  localparam int unsigned PhaseCnt  = 10;
  localparam int unsigned LongHold  = 200;    // cycles the result side holds off once
  localparam int unsigned IdleLimit = 4000;   // watchdog: cycles with no item moving

  // opcode codes the block treats as no operation
  localparam logic [OpcodeW-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OpcodeW-1:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [OpcodeW-1:0] OP_UNUSED_LAST  = 3'd7;

  // opcode mixes of the random phases
  typedef enum int {MIX_FILL, MIX_SEARCH, MIX_DRAIN, MIX_EVEN} op_mix_e;

  // what one result item carries
  typedef struct packed {
    logic [CountOutW-1:0] count;
    logic                 hit;
    logic                 refused;
  } deque_status_t;

  // tracks the deque contents and the status each accepted item should produce
  class deque_tracker;
    logic [ValueW-1:0] ring [Depth];
    int unsigned       head;
    int unsigned       count;
    deque_status_t     awaited[$];
    int                errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function void note_op(logic [OpcodeW-1:0] op, logic [ValueW-1:0] value);
      deque_status_t st;
      int unsigned   i;
      st.hit     = 1'b0;
      st.refused = 1'b0;
      case (op)
        OP_PUSH_FRONT: begin
          if (count == Depth) begin
            st.refused = 1'b1;
          end else begin
            head       = (head + Depth - 1) % Depth;
            ring[head] = value;
            count++;
          end
        end
        OP_PUSH_BACK: begin
          if (count == Depth) begin
            st.refused = 1'b1;
          end else begin
            ring[(head + count) % Depth] = value;
            count++;
          end
        end
        OP_POP_FRONT: begin
          if (count == 0) begin
            st.refused = 1'b1;
          end else begin
            head = (head + 1) % Depth;
            count--;
          end
        end
        OP_POP_BACK: begin
          if (count == 0) st.refused = 1'b1;
          else count--;
        end
        OP_SEARCH: begin
          // only live entries are compared, full 32-bit patterns
          for (i = 0; i < count && !st.hit; i++) begin
            if (ring[(head + i) % Depth] == value) st.hit = 1'b1;
          end
        end
        default: ;
      endcase
      st.count = CountOutW'(count);
      awaited.push_back(st);
    endfunction

    function void check_status(logic [MTdataW-1:0] bus);
      deque_status_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with no item waiting, expected none, actual tdata %h", $time, bus);
        return;
      end
      want = awaited.pop_front();
      if (bus[CountOutW-1:0] !== want.count) begin
        errors++;
        $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                 bus[CountOutW-1:0]);
      end
      if (bus[CountOutW] !== want.hit) begin
        errors++;
        $display("%0t: found expected %b actual %b", $time, want.hit, bus[CountOutW]);
      end
      if (bus[CountOutW+1] !== want.refused) begin
        errors++;
        $display("%0t: refused expected %b actual %b", $time, want.refused, bus[CountOutW+1]);
      end
    endfunction

    // a value currently held (random when empty), so searches and pushes hit existing entries
    function logic [ValueW-1:0] pick_held();
      if (count == 0) return $urandom;
      return ring[(head + $urandom_range(0, count - 1)) % Depth];
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [STdataW-1:0] s_axis_tdata_i;   // [2:0] opcode, [34:3] item_value, [39:35] zero
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [MTdataW-1:0] m_axis_tdata_o;   // [6:0] entry_count, [7] found, [8] refused,
                                        // [15:9] zero

  deque_tracker tracker = new();

  // per-phase idling switches and the one-shot long hold request
  bit send_idle_on;
  bit recv_idle_on;
  bit long_hold_req;
  int unsigned idle_cycles = 0;

  double_ended_queue_with_search_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(input logic [OpcodeW-1:0] op, input logic [ValueW-1:0] value);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(STdataW-OpcodeW-ValueW){1'b0}}, value, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_op(op, value);
  endtask

  // stop offering and wait until every awaited result has come back
  task automatic settle_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited.size() != 0) @(posedge clk_i);
  endtask

  // a mix of full-range values, small values that repeat, the extremes and values already held
  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return ValueW'($urandom_range(0, 15)) - 32'd8;
      5: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return tracker.pick_held();
    endcase
  endfunction

  function automatic logic [OpcodeW-1:0] pick_op(op_mix_e mix);
    int unsigned push_pct, pop_pct, search_pct, r;
    case (mix)
      MIX_FILL:   begin push_pct = 85; pop_pct = 8;  search_pct = 5;  end
      MIX_DRAIN:  begin push_pct = 8;  pop_pct = 85; search_pct = 5;  end
      MIX_SEARCH: begin push_pct = 25; pop_pct = 23; search_pct = 50; end
      default:    begin push_pct = 40; pop_pct = 40; search_pct = 17; end
    endcase
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    if (r < push_pct + pop_pct + search_pct) return OP_SEARCH;
    return OpcodeW'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
  endfunction

  // result side: random stall before each result, one long hold on request
  initial begin
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      stall = recv_idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // every accepted result is checked against the oldest awaited status
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) tracker.check_status(m_axis_tdata_o);
  end

  // watchdog: too long with no item moving on either side ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no item moved for %0d cycles", IdleLimit);
        $display("[double_ended_queue_with_search_core] ERROR");
        $finish;
      end
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_mix_e           mix;
    logic [OpcodeW-1:0] op;
    logic [ValueW-1:0]  value;
    int unsigned        phase, n;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    send_idle_on  = 1'b1;
    recv_idle_on  = 1'b1;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pops and search on an empty deque, the unused opcodes
    send_item(OP_POP_FRONT, 32'h0000_0000);
    send_item(OP_POP_BACK, 32'hffff_ffff);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_UNUSED_FIRST, 32'h1234_5678);
    send_item(OP_UNUSED_MID, 32'h8000_0000);
    send_item(OP_UNUSED_LAST, 32'h7fff_ffff);
    // extreme values at both ends
    send_item(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_item(OP_PUSH_BACK, 32'h8000_0000);
    send_item(OP_PUSH_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_BACK, 32'hffff_ffff);
    // a hit in the middle and one at the front, a miss, an unused opcode on a non-empty deque
    send_item(OP_SEARCH, 32'h8000_0000);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_SEARCH, 32'h1234_5678);
    send_item(OP_UNUSED_LAST, 32'h0000_0000);
    // removal makes the value invisible to search
    send_item(OP_POP_FRONT, 32'h0000_0000);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_POP_BACK, 32'h0000_0000);
    send_item(OP_SEARCH, 32'hffff_ffff);
    send_item(OP_POP_BACK, 32'h0000_0000);
    send_item(OP_POP_FRONT, 32'h0000_0000);
    // empty again with the front index left where it was
    send_item(OP_POP_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_BACK, 32'h0000_0001);
    send_item(OP_SEARCH, 32'h0000_0001);
    send_item(OP_POP_FRONT, 32'h0000_0000);

    // random phases: fill to full, search, drain to empty, even mix
    for (phase = 0; phase < PhaseCnt; phase++) begin
      case (phase % 4)
        0:       mix = MIX_FILL;
        1:       mix = MIX_SEARCH;
        2:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      // one phase runs at full rate on both sides
      send_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      recv_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      // results back up while the sender keeps offering
      if (phase == 2) long_hold_req = 1'b1;
      for (n = 0; n < PhaseLen; n++) begin
        op    = pick_op(mix);
        value = (op == OP_SEARCH && $urandom_range(0, 1)) ? tracker.pick_held() : pick_value();
        send_item(op, value);
      end
      // sender pauses until everything is back
      if (phase % 3 == 2) settle_results();
    end

    settle_results();
    // a search scans at most depth entries
    repeat (Depth + 8) @(posedge clk_i);
    if (tracker.awaited.size() != 0) begin
      tracker.errors++;
      $display("%0t: %0d results expected but missing, actual none", $time,
               tracker.awaited.size());
    end
    if (tracker.errors == 0) begin
      $display("[double_ended_queue_with_search_core] OK");
    end else begin
      $display("[double_ended_queue_with_search_core] ERROR");
    end
    $finish;
  end

endmodule
